### rtl/nms_pkg.sv
// ----------------------------------------------------------------------------
// nms_pkg
// Shared constants, codes and saturating helpers for the nodal matrix stamper.
// ----------------------------------------------------------------------------
package nms_pkg;

  localparam int DEFAULT_MAX_NODES = 16;
  localparam logic [4:0] NODE_COUNT_RESET = 5'd16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_STAMP  = 2'd1;
  localparam logic [1:0] OP_READ_G = 2'd2;
  localparam logic [1:0] OP_READ_V = 2'd3;

  localparam logic [2:0] KIND_RESISTOR  = 3'd0;
  localparam logic [2:0] KIND_CAPACITOR = 3'd1;
  localparam logic [2:0] KIND_INDUCTOR  = 3'd2;
  localparam logic [2:0] KIND_SWITCH    = 3'd3;
  localparam logic [2:0] KIND_VSOURCE   = 3'd4;
  localparam logic [2:0] KIND_DIODE     = 3'd5;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [33:0] acc_t;

  function automatic logic is_ovf(acc_t s);
    return (s[33:31] != 3'b000) && (s[33:31] != 3'b111);
  endfunction

  function automatic q16_t sat32(acc_t s);
    q16_t r;
    if (!is_ovf(s)) begin
      r = s[31:0];
    end else if (s[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

### rtl/nodal_matrix_stamper.sv
// Stamp: no new item is taken until the result is issued; up to four matrix and two vector
//   read-modify-writes run over one read and one write port per memory.
// Matrix/vector read: no new item is taken until the result is issued.
// Clear: sweeps the matrix one entry per cycle, zeroing the vector on the way, then gives a result.
// Reset: synchronous; runs the same clear sweep with in_stall high,
//   node_count returns to 16 and the sticky flag clears.
// ----------------------------------------------------------------------------
// nodal_matrix_stamper
// Accumulates a nodal conductance matrix and source-current vector in two
// synchronous memories, with saturating Q16.16 sums and single-entry reads.
// ----------------------------------------------------------------------------
module nodal_matrix_stamper #(
  parameter int MAX_NODES = nms_pkg::DEFAULT_MAX_NODES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [4:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        operation,
  input  logic [4:0]        node_a,
  input  logic [4:0]        node_b,
  input  logic [2:0]        kind,
  input  logic              is_closed,
  input  logic [30:0]       conductance,
  input  nms_pkg::q16_t     source_current,
  input  logic [3:0]        row_index,
  input  logic [3:0]        col_index,
  output logic              out_valid,
  input  logic              out_stall,
  output nms_pkg::q16_t     read_value,
  output logic              saturated,
  output logic              bad_node
);

  localparam int IW      = $clog2(MAX_NODES);
  localparam int G_DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW      = $clog2(G_DEPTH);
  localparam int CW      = ($clog2(MAX_NODES + 1) > 5) ? $clog2(MAX_NODES + 1) : 5;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [31:0] g_mem [G_DEPTH];
  logic [31:0] v_mem [MAX_NODES];
  logic [31:0] g_rdata;
  logic [31:0] v_rdata;

  logic [1:0]    state;
  logic [4:0]    node_count;
  logic [1:0]    op;
  logic [IW-1:0] ia;
  logic [IW-1:0] ib;
  logic [3:0]    m_en;
  logic [1:0]    v_en;
  logic          item_bad;
  logic [30:0]   g_val;
  nms_pkg::q16_t cur;
  logic [2:0]    step;
  logic [AW-1:0] clr_addr;
  logic          clr_item;
  logic          gw_en;
  logic          gw_neg;
  logic [AW-1:0] gw_addr;
  logic          vw_en;
  logic          vw_neg;
  logic [IW-1:0] vw_addr;
  logic          ovf;
  nms_pkg::q16_t res_value;
  logic          res_bad;

  // item decode
  logic [CW-1:0] n_eff;
  logic          a_nz, b_nz, bad_in, conducts, stamp_ok;
  logic [3:0]    m_en_in;
  logic [1:0]    v_en_in;
  logic [IW-1:0] ia_in, ib_in;

  always_comb begin
    n_eff = (CW'(node_count) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count);
    a_nz  = node_a != 5'd0;
    b_nz  = node_b != 5'd0;
    unique case (operation)
      nms_pkg::OP_CLEAR:  bad_in = 1'b0;
      nms_pkg::OP_STAMP:  bad_in = (CW'(node_a) > n_eff) || (CW'(node_b) > n_eff);
      nms_pkg::OP_READ_G: bad_in = (CW'(row_index) >= n_eff) || (CW'(col_index) >= n_eff);
      nms_pkg::OP_READ_V: bad_in = CW'(row_index) >= n_eff;
    endcase
    conducts = (kind != nms_pkg::KIND_INDUCTOR) &&
               !(((kind == nms_pkg::KIND_SWITCH) || (kind == nms_pkg::KIND_DIODE)) &&
                 !is_closed);
    stamp_ok = (operation == nms_pkg::OP_STAMP) && !bad_in && (node_a != node_b) &&
               (kind <= nms_pkg::KIND_DIODE);
    m_en_in  = {4{stamp_ok && conducts}} & {a_nz && b_nz, a_nz && b_nz, b_nz, a_nz};
    v_en_in  = {2{stamp_ok}} & {b_nz, a_nz};
    ia_in    = (operation == nms_pkg::OP_STAMP) ? IW'(node_a - 5'd1) : IW'(row_index);
    ib_in    = (operation == nms_pkg::OP_STAMP) ? IW'(node_b - 5'd1) : IW'(col_index);
  end

  // access sequencing
  logic [1:0]    sel;
  logic [IW-1:0] r_sel, c_sel;
  logic [AW-1:0] g_raddr;
  logic [IW-1:0] v_raddr;
  logic          issue;

  always_comb begin
    sel = (op == nms_pkg::OP_STAMP) ? step[1:0] : 2'd2;
    case (sel)
      2'd0:    begin r_sel = ia; c_sel = ia; end
      2'd1:    begin r_sel = ib; c_sel = ib; end
      2'd2:    begin r_sel = ia; c_sel = ib; end
      default: begin r_sel = ib; c_sel = ia; end
    endcase
    g_raddr = AW'(r_sel) * AW'(MAX_NODES) + AW'(c_sel);
    v_raddr = (step[0] && (op == nms_pkg::OP_STAMP)) ? ib : ia;
    issue   = (state == S_RUN) && (step <= 3'd3);
  end

  // saturating update
  nms_pkg::acc_t g_ext, c_ext, g_sum, v_sum;
  logic          g_we, v_we;
  logic [AW-1:0] g_waddr;
  logic [IW-1:0] v_waddr;
  logic [31:0]   g_wdata, v_wdata;

  always_comb begin
    g_ext   = {3'b000, g_val};
    c_ext   = {{2{cur[31]}}, cur};
    g_sum   = {{2{g_rdata[31]}}, g_rdata} + (gw_neg ? -g_ext : g_ext);
    v_sum   = {{2{v_rdata[31]}}, v_rdata} + (vw_neg ? -c_ext : c_ext);
    g_we    = (state == S_CLEAR) || gw_en;
    g_waddr = (state == S_CLEAR) ? clr_addr : gw_addr;
    g_wdata = (state == S_CLEAR) ? 32'd0 : nms_pkg::sat32(g_sum);
    v_we    = ((state == S_CLEAR) && (clr_addr < AW'(MAX_NODES))) || vw_en;
    v_waddr = (state == S_CLEAR) ? IW'(clr_addr) : vw_addr;
    v_wdata = (state == S_CLEAR) ? 32'd0 : nms_pkg::sat32(v_sum);
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      g_mem[g_waddr] <= g_wdata;
    end
    g_rdata <= g_mem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      v_mem[v_waddr] <= v_wdata;
    end
    v_rdata <= v_mem[v_raddr];
  end

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      node_count <= nms_pkg::NODE_COUNT_RESET;
      clr_addr   <= '0;
      clr_item   <= 1'b0;
      ovf        <= 1'b0;
      gw_en      <= 1'b0;
      vw_en      <= 1'b0;
      step       <= 3'd0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        node_count <= cfg_data;
      end
      gw_en   <= issue && m_en[step[1:0]];
      gw_addr <= g_raddr;
      gw_neg  <= step[1];
      vw_en   <= issue && (step <= 3'd1) && v_en[step[0]];
      vw_addr <= v_raddr;
      vw_neg  <= step[0];
      if ((gw_en && nms_pkg::is_ovf(g_sum)) || (vw_en && nms_pkg::is_ovf(v_sum))) begin
        ovf <= 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          ovf      <= 1'b0;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(G_DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= clr_item ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op        <= operation;
            ia        <= ia_in;
            ib        <= ib_in;
            m_en      <= m_en_in;
            v_en      <= v_en_in;
            item_bad  <= bad_in;
            g_val     <= conductance;
            cur       <= source_current;
            step      <= 3'd0;
            res_value <= '0;
            res_bad   <= bad_in;
            if (operation == nms_pkg::OP_CLEAR) begin
              clr_item <= 1'b1;
              state    <= S_CLEAR;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          step <= step + 3'd1;
          if ((op != nms_pkg::OP_STAMP) && (step == 3'd1)) begin
            res_value <= item_bad ? '0 :
                         ((op == nms_pkg::OP_READ_G) ? g_rdata : v_rdata);
            state     <= S_DONE;
          end else if (step == 3'd4) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            read_value <= res_value;
            saturated  <= ovf;
            bad_node   <= res_bad;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> (state == S_RUN) || (state == S_CLEAR))
    else $error("transfer in did not start work");

  a_clear_flag: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> !ovf)
    else $error("sticky flag set during clear");

  a_write_in_run: assert property (@(posedge clk) disable iff (rst)
    gw_en || vw_en |-> state == S_RUN)
    else $error("store write outside stamp sequence");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> step <= 3'd4)
    else $error("step counter out of range");

endmodule
